[rtl/mrtu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, constants and the CRC-16 byte step for the RTU frame engine.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // Default sizes of the frame store and the holding-register store.
  localparam int FRAME_BYTES_DEF = 128;
  localparam int REG_DEPTH_DEF   = 64;

  // Response limits.
  localparam int MAX_RESULTS = 64;
  localparam int READ_LIMIT  = (2 * MAX_RESULTS - 5) / 2;
  localparam int WRITE_LIMIT = 123;
  localparam int QTY_W       = 7;

  // Function codes and exception codes.
  localparam logic [7:0] FC_READ_HOLD    = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;
  localparam logic [7:0] EXC_FLAG        = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'd2;
  localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;

  // Minimum frame lengths.
  localparam logic [3:0] MINLEN_SHORT = 4'd8;
  localparam logic [3:0] MINLEN_MULTI = 4'd10;
  localparam logic [3:0] MINLEN_OTHER = 4'd4;
  localparam int         MULTI_OVERHEAD = 9;
  localparam int         MULTI_DATA_START = 7;

  // CRC-16 constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam int         CFG_IDX_W       = 2;
  localparam logic [1:0] CFG_OWN_ADDR    = 2'd0;
  localparam logic [1:0] CFG_REGS_IN_USE = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_WM_HI, ST_WM_LO, ST_WM_WR,
    ST_HDR, ST_BODY_RD, ST_BODY_HI, ST_BODY_LO, ST_CRC_LO, ST_CRC_HI
  } state_t;

  // Outcome of the frame checks.
  typedef enum logic [2:0] {
    K_NONE, K_ERR, K_EXC, K_READ, K_WS, K_WM
  } kind_t;

  // Source of the byte handed to the response packer.
  typedef enum logic [2:0] {
    SRC_HDR, SRC_BODY_HI, SRC_BODY_LO, SRC_CRC_LO, SRC_CRC_HI
  } src_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic scan;
    logic decide;
    logic wm_hi;
    logic wm_lo;
    logic wm_wr;
    logic emit;
    src_t src;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic  clear_done;
    logic  scan_done;
    kind_t kind;
    logic  bc;
    logic  emit_ready;
    logic  hdr_last;
    logic  cnt_last;
  } stat_t;

  // One byte of the reflected CRC-16.
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[rtl/mrtu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mrtu_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_ctrl
// Sequencer for the frame engine: clear pass, frame scan, decision, register
// writes and response emission.
// ----------------------------------------------------------------------------
module mrtu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_end_of_frame,
  input  mrtu_pkg::stat_t stat,
  output logic            in_stall,
  output mrtu_pkg::cmd_t  cmd
);
  import mrtu_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_end_of_frame) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        case (stat.kind)
          K_EXC:   state_nxt = stat.bc ? ST_IDLE : ST_HDR;
          K_READ:  state_nxt = ST_HDR;
          K_WS:    state_nxt = stat.bc ? ST_IDLE : ST_HDR;
          K_WM:    state_nxt = ST_WM_HI;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_WM_HI: state_nxt = ST_WM_LO;
      ST_WM_LO: state_nxt = ST_WM_WR;
      ST_WM_WR: begin
        if (stat.cnt_last) begin
          state_nxt = stat.bc ? ST_IDLE : ST_HDR;
        end else begin
          state_nxt = ST_WM_HI;
        end
      end
      ST_HDR: begin
        if (stat.emit_ready && stat.hdr_last) begin
          state_nxt = (stat.kind == K_READ) ? ST_BODY_RD : ST_CRC_LO;
        end
      end
      ST_BODY_RD: state_nxt = ST_BODY_HI;
      ST_BODY_HI: begin
        if (stat.emit_ready) state_nxt = ST_BODY_LO;
      end
      ST_BODY_LO: begin
        if (stat.emit_ready) state_nxt = stat.cnt_last ? ST_CRC_LO : ST_BODY_RD;
      end
      ST_CRC_LO: begin
        if (stat.emit_ready) state_nxt = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        if (stat.emit_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_HDR;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR:  cmd.clear  = 1'b1;
      ST_IDLE:   cmd.take   = in_valid;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_WM_HI:  cmd.wm_hi  = 1'b1;
      ST_WM_LO:  cmd.wm_lo  = 1'b1;
      ST_WM_WR:  cmd.wm_wr  = 1'b1;
      ST_HDR: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_HDR;
      end
      ST_BODY_HI: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_BODY_HI;
      end
      ST_BODY_LO: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_BODY_LO;
      end
      ST_CRC_LO: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_CRC_LO;
      end
      ST_CRC_HI: begin
        cmd.emit = 1'b1;
        cmd.src  = SRC_CRC_HI;
        cmd.last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/mrtu_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_dp
// Datapath: configuration, frame store, CRC check, frame decision, register
// store and the response packer with its output register.
// ----------------------------------------------------------------------------
module mrtu_dp #(
  parameter int FRAME_BYTES = 128,
  parameter int REG_DEPTH   = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mrtu_pkg::cmd_t                 cmd,
  output mrtu_pkg::stat_t                stat,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_end_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_tx_first,
  output logic [7:0]                     out_tx_second,
  output logic                           out_second_valid,
  output logic                           out_last_of_response,
  output logic [15:0]                    out_errors_seen
);
  import mrtu_pkg::*;

  localparam int CW  = $clog2(FRAME_BYTES + 1);
  localparam int FAW = $clog2(FRAME_BYTES);
  localparam int RAW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;

  // Configuration registers.
  logic [7:0] own_r;
  logic [6:0] riu_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 8'd1;
      riu_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OWN_ADDR)    own_r <= cfg_data;
      if (cfg_index == CFG_REGS_IN_USE) riu_r <= cfg_data[6:0];
    end
  end

  // Frame store and byte counting.
  logic [CW-1:0]  count_r, len_r, scan_idx_r, rd_idx_r;
  logic           ovf_r, lovf_r, rv_r;
  logic           fwe, scan_go;
  logic [FAW-1:0] fa_r, fraddr;
  logic [7:0]     fdata;
  logic [7:0]     f_r [7];
  logic [7:0]     fn2_r, fn1_r, hi_r;
  logic [15:0]    rcrc_r;

  assign fwe     = cmd.take && (count_r < CW'(FRAME_BYTES));
  assign scan_go = cmd.scan && (scan_idx_r != len_r);
  assign fraddr  = cmd.scan ? scan_idx_r[FAW-1:0] : fa_r;

  mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk   (clk),
    .we    (fwe),
    .waddr (count_r[FAW-1:0]),
    .wdata (in_rx_byte),
    .raddr (fraddr),
    .rdata (fdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (in_end_of_frame) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
          rv_r    <= 1'b0;
        end else if (fwe) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.scan) rv_r <= scan_go;
    end
  end

  // Frame length capture and the scan that reads the stored frame back.
  always_ff @(posedge clk) begin
    if (cmd.take && in_end_of_frame) begin
      len_r      <= fwe ? count_r + CW'(1) : count_r;
      lovf_r     <= ovf_r || !fwe;
      scan_idx_r <= '0;
      rcrc_r     <= CRC_INIT;
    end
    if (cmd.scan) begin
      rd_idx_r <= scan_idx_r;
      if (scan_go) scan_idx_r <= scan_idx_r + CW'(1);
    end
    if (rv_r) begin
      if (rd_idx_r < CW'(7)) f_r[rd_idx_r[2:0]] <= fdata;
      if (17'(rd_idx_r) + 17'd2 == 17'(len_r)) fn2_r <= fdata;
      if (17'(rd_idx_r) + 17'd1 == 17'(len_r)) fn1_r <= fdata;
      if (17'(rd_idx_r) + 17'd2 < 17'(len_r)) rcrc_r <= crc_byte(rcrc_r, fdata);
    end
  end

  // Frame checks.
  logic        bc, crc_ok;
  logic [7:0]  fc, exc_code;
  logic [3:0]  minlen;
  logic [15:0] start, qty;
  logic [16:0] iu, l17, s17, sq;
  kind_t       kind;

  always_comb begin
    bc     = (f_r[0] == 8'd0);
    fc     = (len_r >= CW'(2)) ? f_r[1] : 8'd0;
    start  = {f_r[2], f_r[3]};
    qty    = {f_r[4], f_r[5]};
    iu     = ({10'd0, riu_r} > 17'(REG_DEPTH)) ? 17'(REG_DEPTH) : {10'd0, riu_r};
    l17    = 17'(len_r);
    s17    = {1'b0, start};
    sq     = s17 + {1'b0, qty};
    crc_ok = (fn2_r == rcrc_r[7:0]) && (fn1_r == rcrc_r[15:8]);
    if (fc == FC_READ_HOLD || fc == FC_WRITE_SINGLE) minlen = MINLEN_SHORT;
    else if (fc == FC_WRITE_MULTI)                   minlen = MINLEN_MULTI;
    else                                             minlen = MINLEN_OTHER;
    exc_code = EXC_ILLEGAL_FUNC;
    if (lovf_r) begin
      kind = K_ERR;
    end else if (!bc && f_r[0] != own_r) begin
      kind = K_NONE;
    end else if (l17 < 17'(minlen)) begin
      kind = K_ERR;
    end else if (bc && fc == FC_READ_HOLD) begin
      kind = K_ERR;
    end else if (!crc_ok) begin
      kind = K_ERR;
    end else if (fc == FC_READ_HOLD) begin
      if (s17 >= iu) begin
        kind     = K_EXC;
        exc_code = EXC_ILLEGAL_ADDR;
      end else if (qty == 16'd0 || qty > 16'(READ_LIMIT) || sq > iu) begin
        kind     = K_EXC;
        exc_code = EXC_ILLEGAL_VALUE;
      end else begin
        kind = K_READ;
      end
    end else if (fc == FC_WRITE_SINGLE) begin
      if (s17 >= iu) begin
        kind     = K_EXC;
        exc_code = EXC_ILLEGAL_ADDR;
      end else begin
        kind = K_WS;
      end
    end else if (fc == FC_WRITE_MULTI) begin
      if (17'(f_r[6]) != l17 - 17'(MULTI_OVERHEAD)) begin
        kind = K_ERR;
      end else if (s17 >= iu) begin
        kind     = K_EXC;
        exc_code = EXC_ILLEGAL_ADDR;
      end else if (qty == 16'd0 || qty > 16'(WRITE_LIMIT) ||
                   {qty[14:0], 1'b0} != {8'd0, f_r[6]} || sq > iu) begin
        kind     = K_EXC;
        exc_code = EXC_ILLEGAL_VALUE;
      end else begin
        kind = K_WM;
      end
    end else begin
      kind = K_EXC;
    end
  end

  // Register store with its clearing pass.
  logic [RAW-1:0]   clr_r, ra_r, rwaddr;
  logic [QTY_W-1:0] cnt_r;
  logic [15:0]      rwdata, rs_rd;
  logic             rwe;

  always_comb begin
    rwe    = 1'b0;
    rwaddr = ra_r;
    rwdata = {hi_r, fdata};
    if (cmd.clear) begin
      rwe    = 1'b1;
      rwaddr = clr_r;
      rwdata = '0;
    end else if (cmd.decide && kind == K_WS) begin
      rwe    = 1'b1;
      rwaddr = start[RAW-1:0];
      rwdata = qty;
    end else if (cmd.wm_wr) begin
      rwe = 1'b1;
    end
  end

  mrtu_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_regs (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rwdata),
    .raddr (ra_r),
    .rdata (rs_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + RAW'(1);
    end
  end

  // Response packer: header, register body and CRC, up to two bytes per transaction.
  logic [7:0]  hdr_r [6];
  logic        hdr6_r, have0_r;
  logic [2:0]  hk_r;
  logic [15:0] tcrc_r, tally_r;
  logic [7:0]  b0_r, ebyte;
  logic        out_free, emit_ready, fire, push;

  always_comb begin
    case (cmd.src)
      SRC_HDR:     ebyte = hdr_r[hk_r];
      SRC_BODY_HI: ebyte = rs_rd[15:8];
      SRC_BODY_LO: ebyte = rs_rd[7:0];
      SRC_CRC_LO:  ebyte = tcrc_r[7:0];
      SRC_CRC_HI:  ebyte = tcrc_r[15:8];
      default:     ebyte = 8'd0;
    endcase
  end

  assign out_free   = !out_valid || !out_stall;
  assign emit_ready = out_free || (!have0_r && !cmd.last);
  assign fire       = cmd.emit && emit_ready;
  assign push       = fire && (have0_r || cmd.last);

  // Decision actions, register walks and header sequencing.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      hk_r   <= '0;
      tcrc_r <= CRC_INIT;
      ra_r   <= start[RAW-1:0];
      cnt_r  <= qty[QTY_W-1:0];
      fa_r   <= FAW'(MULTI_DATA_START);
      if (kind == K_EXC) begin
        hdr_r[0] <= own_r;
        hdr_r[1] <= fc | EXC_FLAG;
        hdr_r[2] <= exc_code;
        hdr6_r   <= 1'b0;
      end else if (kind == K_READ) begin
        hdr_r[0] <= own_r;
        hdr_r[1] <= fc;
        hdr_r[2] <= {qty[6:0], 1'b0};
        hdr6_r   <= 1'b0;
      end else begin
        for (int i = 0; i < 6; i++) hdr_r[i] <= f_r[i];
        hdr6_r <= 1'b1;
      end
    end
    if (cmd.wm_hi) fa_r <= fa_r + FAW'(1);
    if (cmd.wm_lo) begin
      fa_r <= fa_r + FAW'(1);
      hi_r <= fdata;
    end
    if (cmd.wm_wr) begin
      ra_r  <= ra_r + RAW'(1);
      cnt_r <= cnt_r - QTY_W'(1);
    end
    if (fire) begin
      if (cmd.src == SRC_HDR || cmd.src == SRC_BODY_HI || cmd.src == SRC_BODY_LO) begin
        tcrc_r <= crc_byte(tcrc_r, ebyte);
      end
      if (cmd.src == SRC_HDR) hk_r <= hk_r + 3'd1;
      if (cmd.src == SRC_BODY_LO) begin
        ra_r  <= ra_r + RAW'(1);
        cnt_r <= cnt_r - QTY_W'(1);
      end
      if (!push) b0_r <= ebyte;
    end
  end

  // Error tally, byte pairing and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r   <= '0;
      have0_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide && (kind == K_ERR || kind == K_EXC)) tally_r <= tally_r + 16'd1;
      if (fire) have0_r <= !push;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_tx_first         <= have0_r ? b0_r : ebyte;
      out_tx_second        <= have0_r ? ebyte : 8'd0;
      out_second_valid     <= have0_r;
      out_last_of_response <= cmd.last;
      out_errors_seen      <= tally_r;
    end
  end

  // Status to the sequencer.
  always_comb begin
    stat.clear_done = (clr_r == RAW'(REG_DEPTH - 1));
    stat.scan_done  = (scan_idx_r == len_r) && !rv_r;
    stat.kind       = kind;
    stat.bc         = bc;
    stat.emit_ready = emit_ready;
    stat.hdr_last   = (hk_r == (hdr6_r ? 3'd5 : 3'd2));
    stat.cnt_last   = (cnt_r == QTY_W'(1));
  end

endmodule

[rtl/modbus_rtu_slave_frame_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine_core
// RTU slave frame engine: collects request bytes, checks and executes holding
// register requests and emits the response up to two bytes per transaction.
// ----------------------------------------------------------------------------
// Sequence: a byte without end of frame is written to the frame store. An
// end-of-frame byte starts a frame scan (one stored byte per cycle through the
// frame store read port), a decision, a high-byte, low-byte and write step per
// register for write multiple, then the response bytes with one register-store
// read per register of a read response. Input stays stalled until the frame is
// done, with a response until its last byte is handed to the output register.
// Reset: synchronous; afterwards a clearing pass zeroes every register of the
// register store while the input is stalled.
module modbus_rtu_slave_frame_engine_core #(
  parameter int FRAME_BYTES = mrtu_pkg::FRAME_BYTES_DEF,
  parameter int REG_DEPTH   = mrtu_pkg::REG_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_end_of_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_tx_first,
  output logic [7:0]                     out_tx_second,
  output logic                           out_second_valid,
  output logic                           out_last_of_response,
  output logic [15:0]                    out_errors_seen,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import mrtu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  mrtu_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_frame (in_end_of_frame),
    .stat            (stat),
    .in_stall        (in_stall),
    .cmd             (cmd)
  );

  // Datapath.
  mrtu_dp #(.FRAME_BYTES(FRAME_BYTES), .REG_DEPTH(REG_DEPTH)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_rx_byte           (in_rx_byte),
    .in_end_of_frame      (in_end_of_frame),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_first         (out_tx_first),
    .out_tx_second        (out_tx_second),
    .out_second_valid     (out_second_valid),
    .out_last_of_response (out_last_of_response),
    .out_errors_seen      (out_errors_seen)
  );

  // The clearing pass holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during register clearing pass");

  // An accepted end-of-frame byte starts frame processing.
  a_busy_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_frame |=> in_stall)
    else $error("engine not busy after end of frame");

  // A single trailing byte leaves the second byte zero.
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_second_valid |-> out_tx_second == 8'd0)
    else $error("second byte not zero when unused");

endmodule
